// File: hdl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg
// Shared types, character codes and hex helpers for the command line decoder.
// ----------------------------------------------------------------------------
package scld_pkg;

  localparam int LINE_MAX_DEF    = 11;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LEN_W           = 4;
  localparam int CHAR_W          = 7;

  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  localparam logic [CHAR_W-1:0] CH_TUNE   = 7'h74;
  localparam logic [CHAR_W-1:0] CH_ABORT  = 7'h71;
  localparam logic [CHAR_W-1:0] CH_RECALL = 7'h6C;
  localparam logic [CHAR_W-1:0] CH_DUMP   = 7'h6D;
  localparam logic [CHAR_W-1:0] CH_MREAD  = 7'h65;
  localparam logic [CHAR_W-1:0] CH_AUTO   = 7'h61;
  localparam logic [CHAR_W-1:0] CH_RESET  = 7'h72;
  localparam logic [CHAR_W-1:0] CH_MWRITE = 7'h63;
  localparam logic [CHAR_W-1:0] CH_DEBUG  = 7'h64;
  localparam logic [CHAR_W-1:0] CH_STATUS = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_ONE    = 7'h31;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 7'h39;
  localparam logic [CHAR_W-1:0] CH_LA     = 7'h61;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'h66;
  localparam logic [CHAR_W-1:0] CH_UA     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_UF     = 7'h46;

  localparam logic [LEN_W-1:0] LEN_TUNE   = 4'd6;
  localparam logic [LEN_W-1:0] LEN_RECALL = 4'd6;
  localparam logic [LEN_W-1:0] LEN_MREAD  = 4'd4;
  localparam logic [LEN_W-1:0] LEN_MWRITE = 4'd7;
  localparam logic [LEN_W-1:0] LEN_DEBUG  = 4'd3;

  typedef enum logic [3:0] {
    CMD_TUNE   = 4'd0,
    CMD_ABORT  = 4'd1,
    CMD_RECALL = 4'd2,
    CMD_DUMP   = 4'd3,
    CMD_MREAD  = 4'd4,
    CMD_AUTO   = 4'd5,
    CMD_RESET  = 4'd6,
    CMD_MWRITE = 4'd7,
    CMD_DEBUG  = 4'd8,
    CMD_STATUS = 4'd9,
    CMD_BUSY   = 4'd10,
    CMD_ERROR  = 4'd11
  } cmd_t;

  // finished line as handed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] c0;
    logic [CHAR_W-1:0] c2;
    logic [CHAR_W-1:0] c3;
    logic [CHAR_W-1:0] c4;
    logic [CHAR_W-1:0] c5;
    logic [CHAR_W-1:0] c6;
    logic [LEN_W-1:0]  len;
    logic              busy;
  } line_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // {invalid, value}
  function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return {1'b0, d[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 7'd10;
      return {1'b0, d[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 7'd10;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex2(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b);
    logic [4:0] da;
    logic [4:0] db;
    da = hex_digit(a);
    db = hex_digit(b);
    if (da[4] || db[4]) return 8'h00;
    return {da[3:0], db[3:0]};
  endfunction

  function automatic logic [15:0] hex4(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b,
                                       input logic [CHAR_W-1:0] c,
                                       input logic [CHAR_W-1:0] d);
    logic [4:0] da;
    logic [4:0] db;
    logic [4:0] dc;
    logic [4:0] dd;
    da = hex_digit(a);
    db = hex_digit(b);
    dc = hex_digit(c);
    dd = hex_digit(d);
    if (da[4] || db[4] || dc[4] || dd[4]) return 16'h0000;
    return {da[3:0], db[3:0], dc[3:0], dd[3:0]};
  endfunction

endpackage

// File: hdl/scld_front.sv
// ----------------------------------------------------------------------------
// scld_front
// Takes received words, builds the line store and hands finished lines on.
// ----------------------------------------------------------------------------
module scld_front import scld_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       tuner_busy,
  output logic       push,
  output line_t      line
);

  localparam int IDX_W = $clog2(LINE_MAX);

  logic [CHAR_W-1:0] chars [LINE_MAX];
  logic [LEN_W-1:0]  len;
  logic              accept;
  logic              is_eol;
  logic              is_print;

  assign accept   = in_valid && in_ready;
  assign is_eol   = (rx_byte == BYTE_CR) || (rx_byte == BYTE_LF);
  assign is_print = (rx_byte >= PRINT_LO) && (rx_byte <= PRINT_HI);
  assign push     = accept && is_eol && (len != '0);

  always_comb begin
    line.c0   = chars[0];
    line.c2   = chars[2];
    line.c3   = chars[3];
    line.c4   = chars[4];
    line.c5   = chars[5];
    line.c6   = chars[6];
    line.len  = len;
    line.busy = tuner_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (accept) begin
      if (is_eol) begin
        len <= '0;
      end else if (is_print) begin
        if (len < LEN_W'(LINE_MAX)) begin
          len <= len + 1'b1;
        end
      end else begin
        len <= '0;
      end
    end
  end

  // store has no reset
  always_ff @(posedge clk) begin
    if (accept && !is_eol && is_print && (len < LEN_W'(LINE_MAX))) begin
      chars[len[IDX_W-1:0]] <= rx_byte[CHAR_W-1:0];
    end
  end

endmodule

// File: hdl/scld_queue.sv
// ----------------------------------------------------------------------------
// scld_queue
// Short queue of finished lines between the front and the back.
// ----------------------------------------------------------------------------
module scld_queue import scld_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  line_t         push_line,
  input  logic          pop,
  output line_t         head,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  line_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_line;
    end
  end

endmodule

// File: hdl/scld_back.sv
// ----------------------------------------------------------------------------
// scld_back
// Decodes a finished line into a command word and holds it for the receiver.
// ----------------------------------------------------------------------------
module scld_back import scld_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  line_t         head,
  input  queue_status_t status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    command,
  output logic [15:0]   freq_arg,
  output logic [7:0]    mem_addr,
  output logic [7:0]    mem_data,
  output logic          debug_on
);

  logic        valid;
  cmd_t        cmd;
  logic [15:0] freq;
  logic [7:0]  addr;
  logic [7:0]  data;
  logic        dbg;
  cmd_t        cmd_next;
  logic [15:0] freq_next;
  logic [7:0]  addr_next;
  logic [7:0]  data_next;
  logic        dbg_next;

  assign pop = !status.empty && (!valid || out_ready);

  always_comb begin
    cmd_next  = CMD_ERROR;
    freq_next = '0;
    addr_next = '0;
    data_next = '0;
    dbg_next  = 1'b0;
    if (head.busy && head.c0 != CH_ABORT && head.c0 != CH_STATUS) begin
      cmd_next = CMD_BUSY;
    end else if (head.c0 == CH_TUNE) begin
      cmd_next = CMD_TUNE;
      if (head.len >= LEN_TUNE) begin
        freq_next = hex4(head.c2, head.c3, head.c4, head.c5);
      end
    end else if (head.c0 == CH_ABORT) begin
      cmd_next = CMD_ABORT;
    end else if (head.c0 == CH_RECALL && head.len >= LEN_RECALL) begin
      cmd_next  = CMD_RECALL;
      freq_next = hex4(head.c2, head.c3, head.c4, head.c5);
    end else if (head.c0 == CH_DUMP) begin
      cmd_next = CMD_DUMP;
    end else if (head.c0 == CH_MREAD && head.len >= LEN_MREAD) begin
      cmd_next  = CMD_MREAD;
      addr_next = hex2(head.c2, head.c3);
    end else if (head.c0 == CH_AUTO) begin
      cmd_next = CMD_AUTO;
    end else if (head.c0 == CH_RESET) begin
      cmd_next = CMD_RESET;
    end else if (head.c0 == CH_MWRITE && head.len >= LEN_MWRITE) begin
      cmd_next  = CMD_MWRITE;
      addr_next = hex2(head.c2, head.c3);
      data_next = hex2(head.c5, head.c6);
    end else if (head.c0 == CH_DEBUG) begin
      cmd_next = CMD_DEBUG;
      dbg_next = (head.len >= LEN_DEBUG) && (head.c2 == CH_ONE);
    end else if (head.c0 == CH_STATUS) begin
      cmd_next = CMD_STATUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd  <= cmd_next;
      freq <= freq_next;
      addr <= addr_next;
      data <= data_next;
      dbg  <= dbg_next;
    end
  end

  assign out_valid = valid;
  assign command   = cmd;
  assign freq_arg  = freq;
  assign mem_addr  = addr;
  assign mem_data  = data;
  assign debug_on  = dbg;

endmodule

// File: hdl/serial_command_line_decoder.sv
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Builds text lines from received serial words and decodes each into a command.
// ----------------------------------------------------------------------------
// Input channel: one received word per accepted item (rx_byte) with the
// tuner busy flag, under in_valid / in_ready. Printable words go into the
// line store, CR or LF ends the line, other control words drop the line.
// Output channel: one command word per non-empty line, under out_valid /
// out_ready, with its hex arguments already parsed.
// Throughput: one input word per cycle while in_ready is high. The line
// snapshot is queued at the edge that accepted its line end; it is decoded
// into the output register from the queue head once that register is free.
// Stalls: finished lines wait in a queue of QUEUE_DEPTH entries behind the
// output register; in_ready drops only while that queue is full, so
// characters keep flowing while the receiver holds a command.
// Reset: line length is cleared, the queue is emptied and out_valid falls;
// the line store contents are not cleared.
// ----------------------------------------------------------------------------
module serial_command_line_decoder import scld_pkg::*; #(
  parameter int LINE_MAX    = LINE_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        tuner_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  command,
  output logic [15:0] freq_arg,
  output logic [7:0]  mem_addr,
  output logic [7:0]  mem_data,
  output logic        debug_on
);

  logic          push;
  line_t         line;
  logic          pop;
  line_t         head;
  queue_status_t status;

  assign in_ready = !status.full;

  scld_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .tuner_busy (tuner_busy),
    .push       (push),
    .line       (line)
  );

  scld_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_line (line),
    .pop       (pop),
    .head      (head),
    .status    (status)
  );

  scld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .status    (status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .command   (command),
    .freq_arg  (freq_arg),
    .mem_addr  (mem_addr),
    .mem_data  (mem_data),
    .debug_on  (debug_on)
  );

endmodule

// File: hdl/scld_check.sv
// ----------------------------------------------------------------------------
// scld_check
// Port-level checks on the command output of the line decoder.
// ----------------------------------------------------------------------------
module scld_check import scld_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  command,
  input logic [15:0] freq_arg,
  input logic [7:0]  mem_addr,
  input logic [7:0]  mem_data,
  input logic        debug_on
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(freq_arg)
      && $stable(mem_addr) && $stable(mem_data) && $stable(debug_on))
    else $error("output word changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command <= CMD_ERROR)
    else $error("command code out of range");

  a_freq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != CMD_TUNE && command != CMD_RECALL |-> freq_arg == '0)
    else $error("frequency argument on wrong command");

  a_mem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != CMD_MREAD && command != CMD_MWRITE
      |-> mem_addr == '0 && mem_data == '0 && (debug_on == 1'b0 || command == CMD_DEBUG))
    else $error("argument field set on wrong command");

endmodule

bind serial_command_line_decoder scld_check u_check (.*);
